// ===== rtl/core/pie_pkg.sv =====
`default_nettype none

package pie_pkg;

    // Primitive topology codes. Codes 0 and 11 to 15 are not defined and yield no index.
    typedef enum logic [3:0] {
        TOPO_NONE       = 4'd0,
        TOPO_POINTS     = 4'd1,
        TOPO_LINES      = 4'd2,
        TOPO_LINE_LOOP  = 4'd3,
        TOPO_LINE_STRIP = 4'd4,
        TOPO_TRIS       = 4'd5,
        TOPO_TRI_STRIP  = 4'd6,
        TOPO_FAN        = 4'd7,
        TOPO_QUADS      = 4'd8,
        TOPO_QUAD_STRIP = 4'd9,
        TOPO_POLYGON    = 4'd10
    } topo_t;

    localparam int unsigned IDX_W    = 32;
    localparam int unsigned MAX_RES  = 6;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned POS_W    = 3;
    localparam logic [POS_W-1:0] POS_SAT = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

// ===== rtl/core/primitive_index_expander.sv =====
`default_nettype none

// Converts the vertex indices of a draw, one per input transaction, into list order
// for the topology held in the topology register. Each accepted index yields zero to
// six result transactions. These results go into a six-entry result buffer and leave
// one per cycle while result_stall is low. A new index is accepted in the cycle in
// which the buffer's final result leaves, or sooner if the buffer is empty, so the
// block takes the next index before it is through with the last. Pass-through topologies
// give one result per index and fans give three results per index from the third on.
// Quads give six results on every fourth index, and a quad strip gives six on every
// second index from the fourth on; their other indices give no result. The final index
// of a draw always gives at least one result. When that index yields no vertex, a bare
// end marker with out_valid low stands in its place. Write the topology only while the
// block is idle.
module primitive_index_expander
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [3:0]    topology,

    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire pie_pkg::idx_t vertex_index,
    input  wire logic          draw_last,

    output logic               result_valid,
    input  wire logic          result_stall,
    output pie_pkg::idx_t      out_index,
    output logic               out_valid,
    output logic               run_last,
    output logic               draw_end
);
    import pie_pkg::*;

    topo_t            topology_reg;
    idx_t             first_index_reg, first_index_next;
    idx_t             recent_reg [3];
    idx_t             recent_next [3];
    logic [1:0]       quad_phase_reg, quad_phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    idx_t             buf_reg [MAX_RES];
    idx_t             buf_next [MAX_RES];
    cnt_t             cnt_reg, cnt_next;
    logic             idx_flag_reg, idx_flag_next;
    logic             end_flag_reg, end_flag_next;

    idx_t             res [MAX_RES];
    cnt_t             n;
    idx_t             center;
    logic             take;
    logic             accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= TOPO_NONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            topology_reg <= topo_t'(topology);
        end
    end

    assign result_valid = (cnt_reg != '0);
    assign take         = result_valid && !result_stall;
    assign in_stall     = !((cnt_reg == '0) || ((cnt_reg == cnt_t'(1)) && take));
    assign accept       = in_valid && !in_stall;

    assign out_index = buf_reg[0];
    assign out_valid = idx_flag_reg;
    assign run_last  = (cnt_reg == cnt_t'(1));
    assign draw_end  = (cnt_reg == cnt_t'(1)) && end_flag_reg;

    assign center = (pos_reg == '0) ? vertex_index : first_index_reg;

    // Result list for the incoming index.
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end
        n = '0;
        unique case (topology_reg)
            TOPO_POINTS, TOPO_LINES, TOPO_LINE_STRIP, TOPO_TRIS, TOPO_TRI_STRIP:
            begin
                res[0] = vertex_index;
                n      = cnt_t'(1);
            end
            TOPO_LINE_LOOP:
            begin
                res[0] = vertex_index;
                n      = cnt_t'(1);
                if (draw_last && (pos_reg != '0))
                begin
                    res[1] = center;
                    n      = cnt_t'(2);
                end
            end
            TOPO_FAN, TOPO_POLYGON:
            begin
                if (pos_reg >= POS_W'(2))
                begin
                    res[0] = center;
                    res[1] = recent_reg[0];
                    res[2] = vertex_index;
                    n      = cnt_t'(3);
                end
            end
            TOPO_QUADS:
            begin
                if (quad_phase_reg == 2'd3)
                begin
                    res[0] = recent_reg[2];
                    res[1] = recent_reg[1];
                    res[2] = recent_reg[0];
                    res[3] = recent_reg[2];
                    res[4] = recent_reg[0];
                    res[5] = vertex_index;
                    n      = cnt_t'(6);
                end
            end
            TOPO_QUAD_STRIP:
            begin
                if ((pos_reg >= POS_W'(3)) && quad_phase_reg[0])
                begin
                    res[0] = recent_reg[2];
                    res[1] = recent_reg[1];
                    res[2] = recent_reg[0];
                    res[3] = recent_reg[0];
                    res[4] = recent_reg[1];
                    res[5] = vertex_index;
                    n      = cnt_t'(6);
                end
            end
            default:
            begin
                n = '0;
            end
        endcase
    end

    // Result buffer: loaded on accept, shifted toward entry zero on each output transaction.
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next      = cnt_reg;
        idx_flag_next = idx_flag_reg;
        end_flag_next = end_flag_reg;
        if (accept)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_next[i] = res[i];
            end
            end_flag_next = draw_last;
            if (draw_last && (n == '0))
            begin
                cnt_next      = cnt_t'(1);
                idx_flag_next = 1'b0;
            end
            else
            begin
                cnt_next      = n;
                idx_flag_next = 1'b1;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[MAX_RES-1] = '0;
            cnt_next            = cnt_reg - cnt_t'(1);
        end
    end

    // Draw position state.
    always_comb
    begin
        first_index_next = first_index_reg;
        for (int i = 0; i < 3; i++)
        begin
            recent_next[i] = recent_reg[i];
        end
        quad_phase_next = quad_phase_reg;
        pos_next        = pos_reg;
        if (accept)
        begin
            if (draw_last)
            begin
                first_index_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    recent_next[i] = '0;
                end
                quad_phase_next = '0;
                pos_next        = '0;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    first_index_next = vertex_index;
                end
                recent_next[2]  = recent_reg[1];
                recent_next[1]  = recent_reg[0];
                recent_next[0]  = vertex_index;
                quad_phase_next = quad_phase_reg + 2'd1;
                if (pos_reg < POS_SAT)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                recent_reg[i] <= '0;
            end
            quad_phase_reg <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            idx_flag_reg   <= 1'b0;
            end_flag_reg   <= 1'b0;
        end
        else
        begin
            first_index_reg <= first_index_next;
            for (int i = 0; i < 3; i++)
            begin
                recent_reg[i] <= recent_next[i];
            end
            quad_phase_reg <= quad_phase_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            idx_flag_reg   <= idx_flag_next;
            end_flag_reg   <= end_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cnt_t'(MAX_RES))
        else $error("result count out of range");

    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> result_valid)
        else $error("input stalled with an empty result buffer");

    a_marker_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_valid) |-> draw_end)
        else $error("bare marker without end of draw");

    a_last_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && draw_last) |=> (result_valid && end_flag_reg))
        else $error("final index of a draw gave no result");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
    import pie_pkg::*;

    typedef struct packed {
        idx_t index;
        logic has_vertex;
        logic run_end;
        logic draw_done;
    } expansion_t;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [3:0] TOPO_CODE_MAX = 4'hF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] topology = TOPO_NONE;
    logic in_valid = 1'b0;
    logic in_stall;
    idx_t vertex_index = '0;
    logic draw_last = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    idx_t out_index;
    logic out_valid;
    logic run_last;
    logic draw_end;

    // Shadow of the block's topology register and draw tracking.
    logic [3:0] active_topology = TOPO_NONE;
    idx_t draw_first = '0;
    idx_t recent[3] = '{default: '0};
    logic [1:0] quad_phase = '0;
    logic [2:0] draw_pos = '0;
    expansion_t expanded_due[$];
    expansion_t got_want;

    int mismatch_count = 0;
    int indices_sent = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int take_gap_pct = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    primitive_index_expander u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .topology     (topology),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_index (vertex_index),
        .draw_last    (draw_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_index    (out_index),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .draw_end     (draw_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic expansion_t vertex_of(idx_t v);
        return '{v, 1'b1, 1'b0, 1'b0};
    endfunction

    // Computes the list-order indices that one accepted index adds and queues them.
    function automatic void expand_index(idx_t cur, logic lst);
        expansion_t run[$];
        idx_t center;
        center = (draw_pos == 0) ? cur : draw_first;
        case (active_topology)
            TOPO_POINTS, TOPO_LINES, TOPO_LINE_STRIP, TOPO_TRIS, TOPO_TRI_STRIP:
                run = {run, vertex_of(cur)};
            TOPO_LINE_LOOP:
            begin
                run = {run, vertex_of(cur)};
                // The closing edge exists only when the loop has two or more indices.
                if (lst && draw_pos != 0)
                    run = {run, vertex_of(center)};
            end
            TOPO_FAN, TOPO_POLYGON:
                if (draw_pos >= 2)
                begin
                    run = {run, vertex_of(center)};
                    run = {run, vertex_of(recent[0])};
                    run = {run, vertex_of(cur)};
                end
            TOPO_QUADS:
                if (quad_phase == 2'd3)
                begin
                    run = {run, vertex_of(recent[2])};
                    run = {run, vertex_of(recent[1])};
                    run = {run, vertex_of(recent[0])};
                    run = {run, vertex_of(recent[2])};
                    run = {run, vertex_of(recent[0])};
                    run = {run, vertex_of(cur)};
                end
            TOPO_QUAD_STRIP:
                if (draw_pos >= 3 && quad_phase[0])
                begin
                    run = {run, vertex_of(recent[2])};
                    run = {run, vertex_of(recent[1])};
                    run = {run, vertex_of(recent[0])};
                    run = {run, vertex_of(recent[0])};
                    run = {run, vertex_of(recent[1])};
                    run = {run, vertex_of(cur)};
                end
            default:
                ;
        endcase
        if (lst && run.size() == 0)
            run = {run, expansion_t'('0)};
        if (run.size() != 0)
        begin
            run[run.size() - 1].run_end = 1'b1;
            run[run.size() - 1].draw_done = lst;
        end
        expanded_due = {expanded_due, run};

        if (lst)
        begin
            draw_first = '0;
            recent = '{default: '0};
            quad_phase = '0;
            draw_pos = '0;
        end
        else
        begin
            if (draw_pos == 0)
                draw_first = cur;
            recent[2] = recent[1];
            recent[1] = recent[0];
            recent[0] = cur;
            quad_phase = quad_phase + 2'd1;
            if (draw_pos < POS_SAT)
                draw_pos = draw_pos + 3'd1;
        end
    endfunction

    function automatic idx_t pick_index();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_topology();
        logic [3:0] code;
        if ($urandom_range(99) < 85)
            return 4'($urandom_range(TOPO_POLYGON, TOPO_POINTS));
        // Undefined codes: the upper range plus the all-zero code.
        code = 4'($urandom_range(TOPO_CODE_MAX, TOPO_POLYGON));
        return (code == TOPO_POLYGON) ? 4'(TOPO_NONE) : code;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(24, 10);
        return $urandom_range(8, 1);
    endfunction

    task automatic flag_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_index(idx_t v, logic lst);
        in_valid <= 1'b1;
        vertex_index <= v;
        draw_last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expand_index(v, lst);
        indices_sent++;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_draw(int len);
        for (int i = 0; i < len; i++)
            send_index(pick_index(), i == len - 1);
    endtask

    // Drops valid and waits until every owed result has been taken, then lets an
    // index that produces nothing finish inside the block.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expanded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_topology(logic [3:0] code);
        cfg_valid <= 1'b1;
        topology <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        active_topology = code;
    endtask

    task automatic test_unknown_codes();
        // Topology is still at its reset code here.
        send_index(32'h1234_5678, 1'b1);
        wait_idle();
        write_topology(TOPO_CODE_MAX);
        send_index(pick_index(), 1'b0);
        send_index(pick_index(), 1'b1);
        wait_idle();
    endtask

    task automatic test_passthrough();
        topo_t codes[4] = '{TOPO_LINES, TOPO_LINE_STRIP, TOPO_TRIS, TOPO_TRI_STRIP};
        write_topology(TOPO_POINTS);
        send_index('0, 1'b0);
        send_index('1, 1'b1);
        wait_idle();
        foreach (codes[k])
        begin
            write_topology(codes[k]);
            send_index(pick_index(), 1'b1);
            wait_idle();
        end
    endtask

    task automatic test_line_loop();
        write_topology(TOPO_LINE_LOOP);
        send_index('1, 1'b1);
        wait_idle();
        send_index(32'h0000_0007, 1'b0);
        send_index('0, 1'b1);
        wait_idle();
    endtask

    task automatic test_fan_polygon();
        write_topology(TOPO_FAN);
        send_draw(2);
        wait_idle();
        write_topology(TOPO_POLYGON);
        send_draw(3);
        wait_idle();
    endtask

    task automatic test_quads();
        write_topology(TOPO_QUADS);
        send_draw(5);
        wait_idle();
    endtask

    task automatic test_quad_strip();
        write_topology(TOPO_QUAD_STRIP);
        send_draw(5);
        wait_idle();
    endtask

    task automatic test_switch_mid_draw();
        write_topology(TOPO_FAN);
        send_index(pick_index(), 1'b0);
        send_index(pick_index(), 1'b0);
        wait_idle();
        write_topology(TOPO_QUAD_STRIP);
        send_index(pick_index(), 1'b0);
        send_index(pick_index(), 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        take_gap_pct = 0;
        write_topology(TOPO_FAN);
        hold_toggle <= ~hold_toggle;
        repeat (4) send_draw(10);
        wait_idle();
        write_topology(TOPO_QUADS);
        hold_toggle <= ~hold_toggle;
        repeat (3) send_draw(12);
        wait_idle();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
        int stop_at;
        send_gap_pct = tx_pct;
        take_gap_pct = rx_pct;
        stop_at = indices_sent + count;
        while (indices_sent < stop_at)
        begin
            wait_idle();
            write_topology(pick_topology());
            repeat ($urandom_range(3, 1)) send_draw(pick_len());
            // Now and then a draw is left open so the next setting lands mid-draw.
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1)) send_index(pick_index(), 1'b0);
        end
        wait_idle();
    endtask

    // Result side: random stalls, or a long hold-off when the toggle flips.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < take_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expanded_due.size() == 0)
            begin
                flag_mismatch($sformatf("result transaction with nothing owed, index %h",
                                        out_index));
            end
            else
            begin
                got_want = expanded_due.pop_front();
                if (out_index !== got_want.index)
                    flag_mismatch($sformatf("out_index %h, expected %h",
                                            out_index, got_want.index));
                if (out_valid !== got_want.has_vertex)
                    flag_mismatch($sformatf("out_valid %b, expected %b",
                                            out_valid, got_want.has_vertex));
                if (run_last !== got_want.run_end)
                    flag_mismatch($sformatf("run_last %b, expected %b",
                                            run_last, got_want.run_end));
                if (draw_end !== got_want.draw_done)
                    flag_mismatch($sformatf("draw_end %b, expected %b",
                                            draw_end, got_want.draw_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)
            || (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** primitive_index_expander: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 20;
        take_gap_pct = 20;
        test_unknown_codes();
        test_passthrough();
        test_line_loop();
        test_fan_polygon();
        test_quads();
        test_quad_strip();
        test_switch_mid_draw();
        test_backpressure();
        test_random_traffic(14, 74, 110);
        test_random_traffic(74, 14, 110);
        test_random_traffic(0, 0, 110);
        if (mismatch_count == 0)
            $display("** primitive_index_expander: PASSED **");
        else
            $display("** primitive_index_expander: FAILED **");
        $finish;
    end

endmodule
